### rtl/ptid_pkg.sv
package ptid_pkg;

	localparam int NUM_TIMERS  = 8;
	localparam int NUM_PORTS   = 3;
	localparam int NUM_SOURCES = NUM_TIMERS + NUM_PORTS;
	localparam int SRC_IDX_W   = $clog2(NUM_SOURCES);

	localparam int VEC_W       = 16;
	localparam int CNT_W       = 16;
	localparam int YIELD_W     = 9;
	localparam int THROTTLE_W  = 8;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	localparam logic [YIELD_W-1:0] RESET_YIELD = YIELD_W'(50);
	localparam logic [YIELD_W-1:0] YIELD_MAX   = YIELD_W'(256);

	typedef logic [SRC_IDX_W-1:0] src_idx_t;

	typedef enum logic [2:0] {
		KIND_TICK,
		KIND_PIN,
		KIND_POLL,
		KIND_ADD_TIMER,
		KIND_ADD_PIN
	} kind_t;

	typedef enum logic [1:0] {
		REG_TIMER_EN,
		REG_PIN_EN,
		REG_YIELD
	} reg_idx_t;

	// Load and clear controls for one timer cell
	typedef struct packed {
		logic             load;
		logic             clear_hit;
		logic [VEC_W-1:0] vector;
		logic [CNT_W-1:0] period;
		logic [CNT_W-1:0] start;
	} cell_ctrl_t;

	// Lowest set bit of a source word
	function automatic src_idx_t lowest_src(input logic [NUM_SOURCES-1:0] bits);
		src_idx_t idx;
		logic     found;
		idx   = '0;
		found = 1'b0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (bits[i] && !found) begin
				idx   = SRC_IDX_W'(i);
				found = 1'b1;
			end
		end
		return idx;
	endfunction

endpackage

### rtl/ptid_req_if.sv
interface ptid_req_if;
	import ptid_pkg::*;

	logic             valid;
	logic             ready;
	logic [2:0]       kind;
	logic [2:0]       slot;
	logic [CNT_W-1:0] period;
	logic [VEC_W-1:0] vector;
	logic [CNT_W-1:0] start_count;
	logic [1:0]       port;
	logic [2:0]       port_events;

	modport source (
		output valid, kind, slot, period, vector, start_count, port, port_events,
		input  ready
	);
	modport sink (
		input  valid, kind, slot, period, vector, start_count, port, port_events,
		output ready
	);
endinterface

### rtl/ptid_rsp_if.sv
interface ptid_rsp_if;
	import ptid_pkg::*;

	logic             valid;
	logic             ready;
	logic [VEC_W-1:0] handler;
	logic             served;

	modport source (
		output valid, handler, served,
		input  ready
	);
	modport sink (
		input  valid, handler, served,
		output ready
	);
endinterface

### rtl/ptid_timer_cell.sv
module ptid_timer_cell import ptid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic             token_in,
	output logic             token_out,
	output logic [VEC_W-1:0] vector,
	output logic             hit
);

	logic             token_q;
	logic             hit_q;
	logic [VEC_W-1:0] vector_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] period_q;
	logic [CNT_W-1:0] count_inc;
	logic             advance;
	logic             reached;

	assign count_inc = count_q + CNT_W'(1);
	assign advance   = token_q && (vector_q != '0);
	assign reached   = !(count_inc < period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q  <= 1'b0;
			hit_q    <= 1'b0;
			vector_q <= '0;
		end else begin
			token_q <= token_in;
			if (ctrl.load) begin
				vector_q <= ctrl.vector;
			end
			if (ctrl.clear_hit) begin
				hit_q <= 1'b0;
			end else if (advance && reached) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			count_q  <= ctrl.start;
			period_q <= ctrl.period;
		end else if (advance) begin
			// restart the count once the period is reached
			count_q <= reached ? '0 : count_inc;
		end
	end

	assign token_out = token_q;
	assign vector    = vector_q;
	assign hit       = hit_q;

endmodule

### rtl/periodic_timer_interrupt_dispatcher.sv
// channel | role   | fields
// req     | sink   | kind, slot, period, vector, start_count, port, port_events
// rsp     | source | handler, served (one word per poll)
// apb     | slave  | timer_enable @0x0, pin_enable @0x4, poll_skip @0x8
//
// A tick with timers enabled is accepted, then a token walks the eight timer
// cells, one cell a cycle; no word is accepted until it leaves the last cell.
// Every other kind does not block the input; a poll waits for the response register.
// Reset clears all vectors, hits, pending and throttle state; counts and
// periods are loaded by an add timer request before they are used.
// A stalled response holds its word and blocks further input.
module periodic_timer_interrupt_dispatcher import ptid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ptid_req_if.sink           req,
	ptid_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic                   timer_enable_q;
	logic                   pin_enable_q;
	logic [YIELD_W-1:0]     poll_skip_q;
	logic [NUM_PORTS-1:0]   port_hits_q;
	logic [VEC_W-1:0]       port_vec_q [NUM_PORTS];
	logic [NUM_SOURCES-1:0] pending_q;
	logic [THROTTLE_W-1:0]  throttle_q;
	logic                   rsp_valid_q;
	logic [VEC_W-1:0]       handler_q;
	logic                   served_q;

	cell_ctrl_t             cell_ctrl [NUM_TIMERS];
	logic [NUM_TIMERS:0]    token;
	logic [VEC_W-1:0]       timer_vec [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  timer_hit;
	logic [VEC_W-1:0]       src_vec [NUM_SOURCES];

	logic                   busy;
	logic                   accept;
	logic                   do_tick;
	logic                   do_pin;
	logic                   do_poll;
	logic                   add_timer;
	logic                   add_pin;
	logic                   cfg_write;
	logic [YIELD_W-1:0]     yield_lim;
	logic [YIELD_W-1:0]     throttle_next;
	logic                   hold_off;
	logic                   capture;
	logic [NUM_SOURCES-1:0] pend_src;
	src_idx_t               pend_idx;
	logic [NUM_SOURCES-1:0] pend_clr;
	logic [NUM_PORTS-1:0]   port_armed;

	// ---------------------------------------------------------------- config

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_enable_q <= 1'b0;
			pin_enable_q   <= 1'b0;
			poll_skip_q    <= RESET_YIELD;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_TIMER_EN: timer_enable_q <= pwdata[0];
				REG_PIN_EN:   pin_enable_q   <= pwdata[0];
				REG_YIELD:    poll_skip_q    <= pwdata[YIELD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx_t'(paddr[3:2]))
			REG_TIMER_EN: prdata = PDATA_W'(timer_enable_q);
			REG_PIN_EN:   prdata = PDATA_W'(pin_enable_q);
			REG_YIELD:    prdata = PDATA_W'(poll_skip_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- decode

	assign busy      = |token[NUM_TIMERS:1];
	assign req.ready = !busy && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	always_comb begin
		do_tick   = 1'b0;
		do_pin    = 1'b0;
		do_poll   = 1'b0;
		add_timer = 1'b0;
		add_pin   = 1'b0;
		unique case (req.kind)
			KIND_TICK:      do_tick   = accept && timer_enable_q;
			KIND_PIN:       do_pin    = accept && pin_enable_q;
			KIND_POLL:      do_poll   = accept;
			KIND_ADD_TIMER: add_timer = accept && (req.vector != '0)
				&& ({1'b0, req.slot} < 4'(NUM_TIMERS));
			KIND_ADD_PIN:   add_pin   = accept && (req.vector != '0)
				&& (req.port < 2'(NUM_PORTS));
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- timer chain

	assign token[0] = do_tick;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		always_comb begin
			cell_ctrl[i].load      = add_timer && (req.slot == 3'(i));
			cell_ctrl[i].clear_hit = capture;
			cell_ctrl[i].vector    = req.vector;
			cell_ctrl[i].period    = req.period;
			cell_ctrl[i].start     = req.start_count;
		end

		ptid_timer_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl[i]),
			.token_in  (token[i]),
			.token_out (token[i+1]),
			.vector    (timer_vec[i]),
			.hit       (timer_hit[i])
		);

		assign src_vec[i] = timer_vec[i];
	end

	// ---------------------------------------------------------------- ports

	for (genvar p = 0; p < NUM_PORTS; p++) begin : g_port
		assign port_armed[p]           = port_vec_q[p] != '0;
		assign src_vec[NUM_TIMERS + p] = port_vec_q[p];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				port_vec_q[p] <= '0;
			end else if (add_pin && (req.port == 2'(p))) begin
				port_vec_q[p] <= req.vector;
			end
		end
	end

	// ---------------------------------------------------------------- poll

	assign yield_lim     = (poll_skip_q == '0) ? YIELD_W'(1) :
	                       (poll_skip_q > YIELD_MAX) ? YIELD_MAX : poll_skip_q;
	assign throttle_next = YIELD_W'(throttle_q) + YIELD_W'(1);
	assign hold_off      = (pending_q == '0) && (throttle_next < yield_lim);
	assign capture       = do_poll && !hold_off && (pending_q == '0);
	assign pend_src      = (pending_q == '0) ? {port_hits_q, timer_hit} : pending_q;
	assign pend_idx      = lowest_src(pend_src);
	assign pend_clr      = pend_src & ~(NUM_SOURCES'(1) << pend_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_hits_q <= '0;
			pending_q   <= '0;
			throttle_q  <= '0;
		end else begin
			if (capture) begin
				port_hits_q <= '0;
			end else if (do_pin) begin
				port_hits_q <= port_hits_q | (req.port_events & port_armed);
			end
			if (do_poll) begin
				if (hold_off) begin
					throttle_q <= throttle_next[THROTTLE_W-1:0];
				end else begin
					throttle_q <= '0;
					pending_q  <= pend_clr;
				end
			end
		end
	end

	// ---------------------------------------------------------------- response

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (do_poll) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_poll) begin
			if (!hold_off && (pend_src != '0)) begin
				handler_q <= src_vec[pend_idx];
				served_q  <= 1'b1;
			end else begin
				handler_q <= '0;
				served_q  <= 1'b0;
			end
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.handler = handler_q;
	assign rsp.served  = served_q;

	// ---------------------------------------------------------------- checks

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token[NUM_TIMERS:1]))
		else $error("more than one tick token in the timer chain");

	a_tick_launch: assert property (@(posedge clk) disable iff (!arst_n)
		do_tick |=> token[1])
		else $error("accepted tick did not enter the first cell");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.ready)
		else $error("input taken while a tick walks the chain");

	a_served_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && served_q) |-> (handler_q != '0))
		else $error("served source carries a zero vector");

	a_idle_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !served_q) |-> (handler_q == '0))
		else $error("handler set with nothing served");

endmodule

### verif/tb_periodic_timer_interrupt_dispatcher.sv
`timescale 1ns / 1ps

module tb_periodic_timer_interrupt_dispatcher;
	import ptid_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_CYCLES  = 600;
	localparam int SETTLE_WAIT  = 20;

	// kinds with no meaning, and the port index that names no port
	localparam logic [2:0] KIND_RSVD5 = 3'd5;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;
	localparam logic [1:0] PORT_B     = 2'd0;
	localparam logic [1:0] PORT_C     = 2'd1;
	localparam logic [1:0] PORT_D     = 2'd2;
	localparam logic [1:0] PORT_BAD   = 2'd3;

	typedef struct {
		logic [2:0]       kind;
		logic [2:0]       slot;
		logic [CNT_W-1:0] period;
		logic [VEC_W-1:0] vector;
		logic [CNT_W-1:0] start_count;
		logic [1:0]       port;
		logic [2:0]       port_events;
	} req_word_t;

	typedef struct {
		logic [VEC_W-1:0] handler;
		logic             served;
	} rsp_word_t;

	typedef struct {
		bit               is_cfg;
		reg_idx_t         reg_sel;
		logic [31:0]      cfg_val;
		req_word_t        w;
		bit               typed;
		rsp_word_t        want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	ptid_req_if req_ch();
	ptid_rsp_if rsp_ch();

	periodic_timer_interrupt_dispatcher dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the dispatcher
	logic [VEC_W-1:0]       vec_tab [NUM_SOURCES];
	logic [CNT_W-1:0]       per_tab [NUM_TIMERS];
	logic [CNT_W-1:0]       cnt_tab [NUM_TIMERS];
	logic [3:0]             n_active;
	logic [NUM_TIMERS-1:0]  t_hits;
	logic [NUM_PORTS-1:0]   p_hits;
	logic [NUM_SOURCES-1:0] pend;
	logic [THROTTLE_W-1:0]  thr;
	logic                   t_en;
	logic                   p_en;
	logic [YIELD_W-1:0]     yld;

	rsp_word_t due_handlers[$];
	int        send_idle;
	int        recv_idle;
	int        hold_left;
	int        mismatches;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic predict_dispatch(input req_word_t w, output bit has_rsp,
			output rsp_word_t r);
		logic [CNT_W-1:0] c;
		int  lim;
		int  nxt;
		bit  found;
		has_rsp   = 1'b0;
		r.handler = '0;
		r.served  = 1'b0;
		case (w.kind)
			KIND_TICK: begin
				if (t_en) begin
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (i < n_active && vec_tab[i] != '0) begin
							c = cnt_tab[i] + 1'b1;
							cnt_tab[i] = c;
							if (c >= per_tab[i]) begin
								t_hits[i]  = 1'b1;
								cnt_tab[i] = '0;
							end
						end
					end
				end
			end
			KIND_PIN: begin
				if (p_en) begin
					for (int p = 0; p < NUM_PORTS; p++)
						if (w.port_events[p] && vec_tab[NUM_TIMERS+p] != '0)
							p_hits[p] = 1'b1;
				end
			end
			KIND_POLL: begin
				has_rsp = 1'b1;
				found   = 1'b0;
				lim     = (yld == 0) ? 1 : (yld > 256) ? 256 : int'(yld);
				nxt     = int'(thr) + 1;
				if (pend == '0 && nxt < lim) begin
					thr = THROTTLE_W'(nxt);
				end else begin
					thr = '0;
					if (pend == '0) begin
						pend   = {p_hits, t_hits};
						p_hits = '0;
						t_hits = '0;
					end
					for (int i = 0; i < NUM_SOURCES; i++) begin
						if (pend[i] && !found) begin
							found     = 1'b1;
							pend[i]   = 1'b0;
							r.handler = vec_tab[i];
							r.served  = 1'b1;
						end
					end
				end
			end
			KIND_ADD_TIMER: begin
				if (w.vector != '0 && w.slot < NUM_TIMERS) begin
					vec_tab[w.slot] = w.vector;
					cnt_tab[w.slot] = w.start_count;
					per_tab[w.slot] = w.period;
					if (4'(w.slot) + 4'd1 > n_active)
						n_active = 4'(w.slot) + 4'd1;
				end
			end
			KIND_ADD_PIN: begin
				if (w.vector != '0 && w.port < NUM_PORTS)
					vec_tab[NUM_TIMERS + int'(w.port)] = w.vector;
			end
			default: ;
		endcase
	endtask

	task automatic send_req(input req_word_t w, input bit typed, input rsp_word_t want);
		bit        has_rsp;
		rsp_word_t got;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.kind        <= w.kind;
		req_ch.slot        <= w.slot;
		req_ch.period      <= w.period;
		req_ch.vector      <= w.vector;
		req_ch.start_count <= w.start_count;
		req_ch.port        <= w.port;
		req_ch.port_events <= w.port_events;
		do @(posedge clk); while (!req_ch.ready);
		predict_dispatch(w, has_rsp, got);
		if (has_rsp)
			due_handlers.push_back(typed ? want : got);
	endtask

	// drop valid, drain every response and let a trailing tick finish
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (due_handlers.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		settle();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(idx));
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TIMER_EN: t_en = val[0];
			REG_PIN_EN:   p_en = val[0];
			REG_YIELD:    yld  = val[YIELD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic plan_row_t cfg_row(input reg_idx_t idx, input logic [31:0] val);
		plan_row_t r;
		r         = '{reg_sel: REG_TIMER_EN, default: '0};
		r.is_cfg  = 1'b1;
		r.reg_sel = idx;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic plan_row_t item_row(input logic [2:0] kind, input logic [2:0] slot,
			input logic [15:0] period, input logic [15:0] vector, input logic [15:0] start,
			input logic [1:0] port, input logic [2:0] ev, input bit typed,
			input logic [15:0] h, input logic s);
		plan_row_t r;
		r                 = '{reg_sel: REG_TIMER_EN, default: '0};
		r.w.kind          = kind;
		r.w.slot          = slot;
		r.w.period        = period;
		r.w.vector        = vector;
		r.w.start_count   = start;
		r.w.port          = port;
		r.w.port_events   = ev;
		r.typed           = typed;
		r.want.handler    = h;
		r.want.served     = s;
		return r;
	endfunction

	function automatic req_word_t rand_word();
		req_word_t w;
		int        r;
		r = $urandom_range(99);
		if (r < 34)      w.kind = KIND_TICK;
		else if (r < 48) w.kind = KIND_PIN;
		else if (r < 78) w.kind = KIND_POLL;
		else if (r < 90) w.kind = KIND_ADD_TIMER;
		else if (r < 96) w.kind = KIND_ADD_PIN;
		else             w.kind = 3'($urandom_range(KIND_RSVD7, KIND_RSVD5));
		w.slot        = 3'($urandom_range(7));
		w.period      = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
		w.vector      = ($urandom_range(9) == 0) ? 16'h0 : 16'($urandom);
		w.start_count = ($urandom_range(5) == 0) ? 16'($urandom)
		                                         : 16'($urandom_range(w.period));
		w.port        = 2'($urandom_range(3));
		w.port_events = 3'($urandom_range(7));
		return w;
	endfunction

	task automatic run_phase(input logic ten, input logic pen, input logic [31:0] y,
			input int s_idle, input int r_idle, input int count, input bit hold);
		rsp_word_t none;
		none = '{default: '0};
		write_reg(REG_TIMER_EN, {31'b0, ten});
		write_reg(REG_PIN_EN, {31'b0, pen});
		write_reg(REG_YIELD, y);
		send_idle = s_idle;
		recv_idle = r_idle;
		// hold the receiver off so the response stalls and input backs up
		if (hold)
			hold_left = HOLD_CYCLES;
		repeat (count) send_req(rand_word(), 1'b0, none);
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_word_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_handlers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response word: handler %h served %b",
						rsp_ch.handler, rsp_ch.served);
			end else begin
				e = due_handlers.pop_front();
				if (rsp_ch.handler !== e.handler || rsp_ch.served !== e.served) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response mismatch: expected handler %h served %b, got %h %b",
							e.handler, e.served, rsp_ch.handler, rsp_ch.served);
				end
			end
		end
	end

	initial begin : main
		plan_row_t plan[$];
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		req_ch.valid       = 1'b0;
		req_ch.kind        = '0;
		req_ch.slot        = '0;
		req_ch.period      = '0;
		req_ch.vector      = '0;
		req_ch.start_count = '0;
		req_ch.port        = '0;
		req_ch.port_events = '0;
		send_idle          = 21;
		recv_idle          = 84;
		hold_left          = 0;
		mismatches         = 0;
		for (int i = 0; i < NUM_SOURCES; i++) vec_tab[i] = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			per_tab[i] = '0;
			cnt_tab[i] = '0;
		end
		n_active = '0;
		t_hits   = '0;
		p_hits   = '0;
		pend     = '0;
		thr      = '0;
		t_en     = 1'b0;
		p_en     = 1'b0;
		yld      = RESET_YIELD;

		// throttled poll after reset, zero-vector add timer, pin and tick ignored while disabled
		plan.push_back(item_row(KIND_POLL, 0, 0, 0, 0, PORT_B, 0, 1, 16'h0, 1'b0));
		plan.push_back(item_row(KIND_ADD_TIMER, 0, 3, 16'h0, 0, PORT_B, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_PIN, 0, 0, 0, 0, PORT_B, 3'b111, 0, 0, 0));
		plan.push_back(item_row(KIND_TICK, 0, 0, 0, 0, PORT_B, 0, 0, 0, 0));
		plan.push_back(cfg_row(REG_TIMER_EN, 32'd1));
		plan.push_back(cfg_row(REG_PIN_EN, 32'd1));
		plan.push_back(cfg_row(REG_YIELD, 32'd1));
		// zero period, top slot with top period, wrapping count, bad port
		plan.push_back(item_row(KIND_ADD_TIMER, 0, 16'h0, 16'hFFFF, 16'h0, PORT_B, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_ADD_TIMER, 7, 16'hFFFF, 16'h0001, 16'hFFFE, PORT_D, 0,
			0, 0, 0));
		plan.push_back(item_row(KIND_ADD_TIMER, 3, 16'h2, 16'h1234, 16'hFFFF, PORT_C, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_ADD_PIN, 0, 0, 16'hAAAA, 0, PORT_BAD, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_ADD_PIN, 0, 0, 16'h8000, 0, PORT_B, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_ADD_PIN, 0, 0, 16'h0002, 0, PORT_D, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_TICK, 0, 0, 0, 0, PORT_B, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_PIN, 0, 0, 0, 0, PORT_B, 3'b111, 0, 0, 0));
		repeat (4) plan.push_back(item_row(KIND_POLL, 0, 0, 0, 0, PORT_B, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_POLL, 0, 0, 0, 0, PORT_B, 0, 1, 16'h0, 1'b0));
		plan.push_back(item_row(KIND_RSVD5, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, PORT_BAD, 3'b111,
			0, 0, 0));
		plan.push_back(item_row(KIND_RSVD6, 0, 0, 0, 0, PORT_B, 0, 0, 0, 0));
		plan.push_back(item_row(KIND_RSVD7, 0, 0, 0, 0, PORT_B, 0, 0, 0, 0));
		repeat (2) plan.push_back(item_row(KIND_TICK, 0, 0, 0, 0, PORT_B, 0, 0, 0, 0));
		plan.push_back(cfg_row(REG_YIELD, 32'd0));
		repeat (3) plan.push_back(item_row(KIND_POLL, 0, 0, 0, 0, PORT_B, 0, 0, 0, 0));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].reg_sel, plan[i].cfg_val);
			else
				send_req(plan[i].w, plan[i].typed, plan[i].want);
		end

		run_phase(1'b1, 1'b1, 32'd1,   21, 84, 300, 1'b1);
		run_phase(1'b1, 1'b1, 32'd256, 21, 84, 100, 1'b0);
		run_phase(1'b0, 1'b1, 32'd4,   84, 21, 150, 1'b0);
		run_phase(1'b1, 1'b0, 32'd0,   84, 21, 250, 1'b0);
		run_phase(1'b1, 1'b1, 32'd511, 84, 21, 100, 1'b0);
		run_phase(1'b1, 1'b1, 32'd2,    0,  0, 400, 1'b1);
		run_phase(1'b1, 1'b1, 32'd7,    0,  0, 275, 1'b0);
		settle();

		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
